FILE: rtl/core/sat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants
// Field widths, function and status codes, sequencer states and the command
// word of the shared accumulator for the summed-area table block.
// ----------------------------------------------------------------------------
package sat_pkg;

  // field and register widths
  localparam int DIM_W     = 8;
  localparam int IDX_W     = 13;
  localparam int ENTRY_W   = 22;
  localparam int FUNC_W    = 2;
  localparam int CELL_W    = 8;
  localparam int CORNER_W  = 7;
  localparam int SIDE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // function codes
  localparam logic [FUNC_W-1:0] FN_RESTART = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOAD_END  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  // grid size after reset
  localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_L_CELL,
    S_L_ABOVE,
    S_L_WR,
    S_Q1,
    S_Q2,
    S_Q3,
    S_Q4,
    S_DONE
  } state_t;

  // accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SET,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    acc_op_t                   op;
    logic [ENTRY_W-1:0]        operand;
  } acc_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/sat_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_in_if: input channel
// Valid/ready channel carrying one command item (load, restart or query).
// ----------------------------------------------------------------------------
interface sat_in_if;
  logic                            valid;
  logic                            ready;
  logic [sat_pkg::FUNC_W-1:0]      func;
  logic [sat_pkg::CELL_W-1:0]      cell_value;
  logic [sat_pkg::CORNER_W-1:0]    top_row;
  logic [sat_pkg::CORNER_W-1:0]    left_col;
  logic [sat_pkg::SIDE_W-1:0]      side;

  modport source (
    output valid, func, cell_value, top_row, left_col, side,
    input  ready
  );

  modport sink (
    input  valid, func, cell_value, top_row, left_col, side,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/sat_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_out_if: result channel
// Valid/ready channel carrying one result item (sum and status).
// ----------------------------------------------------------------------------
interface sat_out_if;
  logic                            valid;
  logic                            ready;
  logic [sat_pkg::ENTRY_W-1:0]     sum;
  logic [sat_pkg::STATUS_W-1:0]    status;

  modport source (
    output valid, sum, status,
    input  ready
  );

  modport sink (
    input  valid, sum, status,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/sat_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_ram: single-port table memory
// One access per cycle: a write, or a read with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int ADDR_W = 14,
  parameter int DEPTH  = 16384,
  parameter int DATA_W = 22
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write, or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sat_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_acc: shared accumulator
// Single add/subtract unit, modulo the entry width, used by every step of
// the load and query sequences.
// ----------------------------------------------------------------------------
module sat_acc (
  input  wire logic                         clk,
  input  wire sat_pkg::acc_cmd_t            cmd,
  output logic      [sat_pkg::ENTRY_W-1:0]  acc_r
);

  logic [sat_pkg::ENTRY_W-1:0] acc_nxt;

  // one operation a cycle
  always_comb begin
    case (cmd.op)
      sat_pkg::ACC_SET: acc_nxt = cmd.operand;
      sat_pkg::ACC_ADD: acc_nxt = acc_r + cmd.operand;
      sat_pkg::ACC_SUB: acc_nxt = acc_r - cmd.operand;
      default:          acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/summed_area_table_square_query.sv
// Items are handled one at a time: a new item is taken only once the result of the last one
// is in the output register. A load runs plan, cell, above and write steps, and a query runs
// plan and four corner steps. The single-port table memory and the one shared accumulator
// give one table access and one add per cycle.
// Reset: synchronous, active low; clears sequencer, load position and grid size to
// 128 x 128. Table contents stay undefined until loaded; there is no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// summed_area_table_square_query: summed-area table with square-sum queries
// Builds a 2-D prefix-sum table from cells loaded in raster order and answers
// square-sum queries from four corner lookups, through one memory port and
// one shared accumulator under a small sequencer.
// ----------------------------------------------------------------------------
module summed_area_table_square_query #(
  parameter int MAX_ROWS   = 128,
  parameter int MAX_COLS   = 128,
  parameter int VALUE_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  sat_in_if.sink                                  in_chan,
  sat_out_if.source                               out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sat_pkg::DIM_W-1:0]          cfg_wdata
);

  localparam int DW     = sat_pkg::DIM_W;
  localparam int IW     = sat_pkg::IDX_W;
  localparam int EW     = sat_pkg::ENTRY_W;
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int AW     = ROW_AW + COL_AW;
  localparam int DEPTH  = MAX_ROWS << COL_AW;
  localparam logic [sat_pkg::CELL_W-1:0] VAL_MASK =
    (VALUE_BITS >= sat_pkg::CELL_W) ? {sat_pkg::CELL_W{1'b1}}
                                    : sat_pkg::CELL_W'((1 << VALUE_BITS) - 1);

  // table address from row and column
  function automatic logic [AW-1:0] addr_of(input logic [DW-1:0] r, input logic [DW-1:0] c);
    logic [IW-1:0] re;
    logic [IW-1:0] ce;
    re = IW'(r);
    ce = IW'(c);
    return {re[ROW_AW-1:0], ce[COL_AW-1:0]};
  endfunction

  sat_pkg::state_t                 state_r, state_nxt;
  logic [sat_pkg::FUNC_W-1:0]      func_r, func_nxt;
  logic [sat_pkg::CELL_W-1:0]      cell_r, cell_nxt;
  logic [sat_pkg::CORNER_W-1:0]    qtop_r, qtop_nxt;
  logic [sat_pkg::CORNER_W-1:0]    qleft_r, qleft_nxt;
  logic [sat_pkg::SIDE_W-1:0]      side_r, side_nxt;
  logic [DW-1:0]                   row_count_r, row_count_nxt;
  logic [DW-1:0]                   col_count_r, col_count_nxt;
  logic [EW-1:0]                   run_r, run_nxt;
  logic [DW-1:0]                   load_row_r, load_row_nxt;
  logic [DW-1:0]                   load_col_r, load_col_nxt;
  logic                            complete_r, complete_nxt;
  logic                            use_acc_r, use_acc_nxt;
  logic [sat_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [EW-1:0]                   out_sum_r, out_sum_nxt;
  logic [sat_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  logic [DW-1:0]                   rows_use;
  logic [DW-1:0]                   cols_use;
  logic [DW:0]                     q_row_end;
  logic [DW:0]                     q_col_end;
  logic [DW-1:0]                   br;
  logic [DW-1:0]                   bc;
  logic [DW-1:0]                   tm1;
  logic [DW-1:0]                   lm1;
  logic                            up;
  logic                            lf;
  logic                            load_ok;
  logic                            q_zero;
  logic                            q_bad;
  logic [EW-1:0]                   cell_ext;
  logic [DW-1:0]                   col_inc;
  logic [DW-1:0]                   row_inc;
  logic                            out_free;
  logic                            in_ready;

  logic                            ram_we;
  logic [AW-1:0]                   ram_addr;
  logic [EW-1:0]                   ram_rdata;
  sat_pkg::acc_cmd_t               acc_cmd;
  logic [EW-1:0]                   acc_val;

  sat_ram #(
    .ADDR_W (AW),
    .DEPTH  (DEPTH),
    .DATA_W (EW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   (acc_val),
    .rdata_r (ram_rdata)
  );

  sat_acc u_acc (
    .clk   (clk),
    .cmd   (acc_cmd),
    .acc_r (acc_val)
  );

  // grid size in use, clamped to 1..max
  assign rows_use = (row_count_r == '0) ? DW'(1)
                  : (IW'(row_count_r) > IW'(MAX_ROWS)) ? DW'(MAX_ROWS) : row_count_r;
  assign cols_use = (col_count_r == '0) ? DW'(1)
                  : (IW'(col_count_r) > IW'(MAX_COLS)) ? DW'(MAX_COLS) : col_count_r;

  // query corners and checks
  assign q_row_end = (DW+1)'(qtop_r) + (DW+1)'(side_r);
  assign q_col_end = (DW+1)'(qleft_r) + (DW+1)'(side_r);
  assign br        = DW'(q_row_end - (DW+1)'(1));
  assign bc        = DW'(q_col_end - (DW+1)'(1));
  assign tm1       = DW'(qtop_r) - DW'(1);
  assign lm1       = DW'(qleft_r) - DW'(1);
  assign up        = (qtop_r != '0);
  assign lf        = (qleft_r != '0);
  assign q_zero    = (side_r == '0);
  assign q_bad     = !complete_r || (q_row_end > (DW+1)'(rows_use))
                                 || (q_col_end > (DW+1)'(cols_use));

  // load checks
  assign load_ok   = !complete_r && (load_row_r < rows_use) && (load_col_r < cols_use);
  assign cell_ext  = EW'(cell_r & VAL_MASK);
  assign col_inc   = load_col_r + DW'(1);
  assign row_inc   = load_row_r + DW'(1);

  assign out_free  = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sat_pkg::S_IDLE: begin
        if (in_chan.valid) state_nxt = sat_pkg::S_PLAN;
      end
      sat_pkg::S_PLAN: begin
        case (func_r)
          sat_pkg::FN_LOAD:  state_nxt = load_ok ? sat_pkg::S_L_CELL : sat_pkg::S_DONE;
          sat_pkg::FN_QUERY: state_nxt = (q_zero || q_bad) ? sat_pkg::S_DONE : sat_pkg::S_Q1;
          default:           state_nxt = sat_pkg::S_DONE;
        endcase
      end
      sat_pkg::S_L_CELL:  state_nxt = sat_pkg::S_L_ABOVE;
      sat_pkg::S_L_ABOVE: state_nxt = sat_pkg::S_L_WR;
      sat_pkg::S_L_WR:    state_nxt = sat_pkg::S_DONE;
      sat_pkg::S_Q1:      state_nxt = sat_pkg::S_Q2;
      sat_pkg::S_Q2:      state_nxt = sat_pkg::S_Q3;
      sat_pkg::S_Q3:      state_nxt = sat_pkg::S_Q4;
      sat_pkg::S_Q4:      state_nxt = sat_pkg::S_DONE;
      sat_pkg::S_DONE: begin
        if (out_free) state_nxt = sat_pkg::S_IDLE;
      end
      default:            state_nxt = sat_pkg::S_IDLE;
    endcase
  end

  // memory port, accumulator and handshake per state
  always_comb begin
    in_ready        = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = addr_of(load_row_r, load_col_r);
    acc_cmd.op      = sat_pkg::ACC_HOLD;
    acc_cmd.operand = '0;
    case (state_r)
      sat_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      sat_pkg::S_PLAN: begin
        if (func_r == sat_pkg::FN_LOAD) begin
          // read the entry above, start from the row's running sum
          ram_addr        = addr_of(load_row_r - DW'(1), load_col_r);
          acc_cmd.op      = sat_pkg::ACC_SET;
          acc_cmd.operand = run_r;
        end else begin
          // read the bottom-right corner
          ram_addr        = addr_of(br, bc);
          acc_cmd.op      = sat_pkg::ACC_SET;
        end
      end
      sat_pkg::S_L_CELL: begin
        // keep the entry above on the read port for the next step
        ram_addr        = addr_of(load_row_r - DW'(1), load_col_r);
        acc_cmd.op      = sat_pkg::ACC_ADD;
        acc_cmd.operand = cell_ext;
      end
      sat_pkg::S_L_ABOVE: begin
        acc_cmd.op      = sat_pkg::ACC_ADD;
        acc_cmd.operand = (load_row_r != '0) ? ram_rdata : '0;
      end
      sat_pkg::S_L_WR: begin
        ram_we = 1'b1;
      end
      sat_pkg::S_Q1: begin
        ram_addr        = addr_of(tm1, lm1);
        acc_cmd.op      = sat_pkg::ACC_ADD;
        acc_cmd.operand = ram_rdata;
      end
      sat_pkg::S_Q2: begin
        ram_addr        = addr_of(br, lm1);
        acc_cmd.op      = sat_pkg::ACC_ADD;
        acc_cmd.operand = (up && lf) ? ram_rdata : '0;
      end
      sat_pkg::S_Q3: begin
        ram_addr        = addr_of(tm1, bc);
        acc_cmd.op      = sat_pkg::ACC_SUB;
        acc_cmd.operand = lf ? ram_rdata : '0;
      end
      sat_pkg::S_Q4: begin
        acc_cmd.op      = sat_pkg::ACC_SUB;
        acc_cmd.operand = up ? ram_rdata : '0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // register updates
  always_comb begin
    func_nxt       = func_r;
    cell_nxt       = cell_r;
    qtop_nxt       = qtop_r;
    qleft_nxt      = qleft_r;
    side_nxt       = side_r;
    row_count_nxt  = row_count_r;
    col_count_nxt  = col_count_r;
    run_nxt        = run_r;
    load_row_nxt   = load_row_r;
    load_col_nxt   = load_col_r;
    complete_nxt   = complete_r;
    use_acc_nxt    = use_acc_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_sum_nxt    = out_sum_r;
    out_status_nxt = out_status_r;

    // capture the item on transfer
    if (state_r == sat_pkg::S_IDLE && in_chan.valid) begin
      func_nxt  = in_chan.func;
      cell_nxt  = in_chan.cell_value;
      qtop_nxt  = in_chan.top_row;
      qleft_nxt = in_chan.left_col;
      side_nxt  = in_chan.side;
    end

    // decide the result kind
    if (state_r == sat_pkg::S_PLAN) begin
      use_acc_nxt = 1'b0;
      status_nxt  = sat_pkg::ST_OK;
      case (func_r)
        sat_pkg::FN_RESTART: begin
          run_nxt      = '0;
          load_row_nxt = '0;
          load_col_nxt = '0;
          complete_nxt = 1'b0;
        end
        sat_pkg::FN_LOAD: begin
          use_acc_nxt = load_ok;
          if (!load_ok) status_nxt = sat_pkg::ST_LOAD_END;
        end
        sat_pkg::FN_QUERY: begin
          use_acc_nxt = !q_zero && !q_bad;
          if (!q_zero && q_bad) status_nxt = sat_pkg::ST_BAD_QUERY;
        end
        default: begin
          use_acc_nxt = 1'b0;
        end
      endcase
    end

    // running sum includes the new cell
    if (state_r == sat_pkg::S_L_ABOVE) begin
      run_nxt = acc_val;
    end

    // advance the raster position
    if (state_r == sat_pkg::S_L_WR) begin
      if (col_inc >= cols_use) begin
        load_col_nxt = '0;
        run_nxt      = '0;
        load_row_nxt = row_inc;
        if (row_inc >= rows_use) complete_nxt = 1'b1;
      end else begin
        load_col_nxt = col_inc;
      end
    end

    // output register
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    if (state_r == sat_pkg::S_DONE && out_free) begin
      out_valid_nxt  = 1'b1;
      out_sum_nxt    = use_acc_r ? acc_val : '0;
      out_status_nxt = status_r;
    end

    // configuration write restarts loading
    if (cfg_we) begin
      case (cfg_index)
        sat_pkg::CFG_ROW_COUNT: row_count_nxt = cfg_wdata;
        sat_pkg::CFG_COL_COUNT: col_count_nxt = cfg_wdata;
        default:                row_count_nxt = row_count_r;
      endcase
      run_nxt      = '0;
      load_row_nxt = '0;
      load_col_nxt = '0;
      complete_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sat_pkg::S_IDLE;
      row_count_r <= sat_pkg::DIM_RESET;
      col_count_r <= sat_pkg::DIM_RESET;
      run_r       <= '0;
      load_row_r  <= '0;
      load_col_r  <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      run_r       <= run_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      complete_r  <= complete_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    cell_r       <= cell_nxt;
    qtop_r       <= qtop_nxt;
    qleft_r      <= qleft_nxt;
    side_r       <= side_nxt;
    use_acc_r    <= use_acc_nxt;
    status_r     <= status_nxt;
    out_sum_r    <= out_sum_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_chan.ready   = in_ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.sum    = out_sum_r;
  assign out_chan.status = out_status_r;

`ifndef SYNTH
  // load column always inside the grid in use
  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    load_col_r < cols_use)
    else $error("load column outside grid");

  // a complete table sits at the start of the row past the last
  a_complete_pos: assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> (load_row_r == rows_use) && (load_col_r == '0))
    else $error("table complete at wrong load position");

  // an error result never carries a sum
  a_err_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != sat_pkg::ST_OK)) |-> (out_sum_r == '0))
    else $error("error result with non-zero sum");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_summed_area_table_square_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_summed_area_table_square_query: self-checking bench for the prefix-sum block
// Loads grids of several shapes in raster order, including the one-row and
// one-column extremes. Fires square-sum queries, restarts and stray commands
// with random idling on both channels and one long result back-pressure
// stretch. Every result is checked against a local prefix-sum predictor or a typed expectation.
// ----------------------------------------------------------------------------
module tb_summed_area_table_square_query;
  import sat_pkg::*;

  localparam int GRID_MAX      = 128;
  localparam int TARGET_ITEMS  = 750;
  localparam int GAP_PCT       = 23;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam int SMALL_DIM     = 8;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [CELL_W-1:0]   cell_value;
    logic [CORNER_W-1:0] top_row;
    logic [CORNER_W-1:0] left_col;
    logic [SIDE_W-1:0]   side;
  } sat_cmd_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]  sum;
    logic [STATUS_W-1:0] status;
  } sat_result_t;

  typedef struct packed {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DIM_W-1:0]     reg_value;
    sat_cmd_t             cmd;
    logic                 typed;
    sat_result_t          want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  sat_in_if  in_if ();
  sat_out_if out_if ();

  summed_area_table_square_query u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [ENTRY_W-1:0] prefix_sums [GRID_MAX*GRID_MAX];
  int unsigned        row_sum_acc;
  int                 load_r;
  int                 load_c;
  bit                 grid_loaded;
  logic [DIM_W-1:0]   rows_reg;
  logic [DIM_W-1:0]   cols_reg;

  sat_result_t pending_results [$];
  int error_count;
  int items_sent;
  int results_seen;
  bit no_gaps;

  // directed table: expected values typed only where obvious
  stim_row_t directed_rows [28] = '{
    // zero side, then a query before any loading, at reset size
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   0,   0,   0}, 1, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   0,   0,   1}, 1, '{0, ST_BAD_QUERY}},
    '{0, CFG_ROW_COUNT, 0, '{FN_UNUSED, 255, 127, 127, 255}, 1, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,   200,   0,   0,   0}, 1, '{200, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_RESTART,  0,   0,   0,   0}, 1, '{0, ST_OK}},
    // 2 x 3 grid with extreme cell values
    '{1, CFG_ROW_COUNT, 2, '{FN_RESTART,  0,   0,   0,   0}, 0, '{0, ST_OK}},
    '{1, CFG_COL_COUNT, 3, '{FN_RESTART,  0,   0,   0,   0}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,   255,   0,   0,   0}, 1, '{255, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,     0,   0,   0,   0}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,   255,   0,   0,   0}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,     1,   0,   0,   0}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,   255,   0,   0,   0}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,   128,   0,   0,   0}, 0, '{0, ST_OK}},
    // load past the grid end
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,    77,   0,   0,   0}, 1, '{0, ST_LOAD_END}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   0,   0,   2}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   1,   2,   1}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   0,   1,   2}, 0, '{0, ST_OK}},
    // squares reaching out of the grid, then a zero side
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   1,   0,   2}, 1, '{0, ST_BAD_QUERY}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0, 127, 127, 255}, 1, '{0, ST_BAD_QUERY}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   0,   0, 128}, 1, '{0, ST_BAD_QUERY}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0, 127, 127,   0}, 1, '{0, ST_OK}},
    // restart drops the finished table
    '{0, CFG_ROW_COUNT, 0, '{FN_RESTART,  0,   0,   0,   0}, 1, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   0,   0,   1}, 1, '{0, ST_BAD_QUERY}},
    // zero row count behaves as one row: 1 x 1 grid
    '{1, CFG_ROW_COUNT, 0, '{FN_RESTART,  0,   0,   0,   0}, 0, '{0, ST_OK}},
    '{1, CFG_COL_COUNT, 1, '{FN_RESTART,  0,   0,   0,   0}, 0, '{0, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,   255,   0,   0,   0}, 1, '{255, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_QUERY,    0,   0,   0,   1}, 1, '{255, ST_OK}},
    '{0, CFG_ROW_COUNT, 0, '{FN_LOAD,     9,   0,   0,   0}, 1, '{0, ST_LOAD_END}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic int dim_in_use(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    return (v > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  // entries left of column 0 or above row 0 read as zero
  function automatic logic [ENTRY_W-1:0] prefix_at(int r, int c);
    if (r < 0 || c < 0) return '0;
    return prefix_sums[r*GRID_MAX + c];
  endfunction

  function automatic void restart_grid();
    row_sum_acc = 0;
    load_r      = 0;
    load_c      = 0;
    grid_loaded = 1'b0;
  endfunction

  // prefix entry stored by a load, or the sum over a queried square
  function automatic sat_result_t compute_table_result(sat_cmd_t c);
    sat_result_t res;
    int rows;
    int cols;
    int top;
    int left;
    int side;
    int br;
    int bc;
    res.sum    = '0;
    res.status = ST_OK;
    rows = dim_in_use(rows_reg);
    cols = dim_in_use(cols_reg);
    case (c.func)
      FN_RESTART: restart_grid();
      FN_LOAD: begin
        if (grid_loaded || load_r >= rows || load_c >= cols) begin
          res.status = ST_LOAD_END;
        end else begin
          row_sum_acc += c.cell_value;
          res.sum = ENTRY_W'(row_sum_acc) + prefix_at(load_r - 1, load_c);
          prefix_sums[load_r*GRID_MAX + load_c] = res.sum;
          load_c++;
          if (load_c >= cols) begin
            load_c      = 0;
            row_sum_acc = 0;
            load_r++;
            if (load_r >= rows) grid_loaded = 1'b1;
          end
        end
      end
      FN_QUERY: begin
        top  = c.top_row;
        left = c.left_col;
        side = c.side;
        if (side != 0) begin
          if (!grid_loaded || top + side > rows || left + side > cols) begin
            res.status = ST_BAD_QUERY;
          end else begin
            br = top + side - 1;
            bc = left + side - 1;
            res.sum = prefix_at(br, bc) + prefix_at(top - 1, left - 1)
                    - prefix_at(br, left - 1) - prefix_at(top - 1, bc);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic sat_cmd_t random_cmd(logic [FUNC_W-1:0] f);
    sat_cmd_t c;
    c.func       = f;
    c.cell_value = CELL_W'($urandom_range(0, 255));
    c.top_row    = CORNER_W'($urandom_range(0, 127));
    c.left_col   = CORNER_W'($urandom_range(0, 127));
    c.side       = SIDE_W'($urandom_range(0, 255));
    return c;
  endfunction

  // cell values leaning towards the extremes
  function automatic logic [CELL_W-1:0] random_cell();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CELL_W'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // one input transfer; called and returns at a falling edge
  task automatic send_item(input sat_cmd_t c, input logic typed, input sat_result_t want);
    sat_result_t got;
    while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= c.func;
    in_if.cell_value <= c.cell_value;
    in_if.top_row    <= c.top_row;
    in_if.left_col   <= c.left_col;
    in_if.side       <= c.side;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    got = compute_table_result(c);
    pending_results.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  // register write once the block has drained
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_COUNT) rows_reg = value;
    else cols_reg = value;
    restart_grid();
  endtask

  // result side ready, with one long hold-off to back the block up
  initial begin
    bit held_off;
    held_off     = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_if.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    sat_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum %0d status %0d",
                                  out_if.sum, out_if.status));
      end else begin
        want = pending_results.pop_front();
        if (out_if.sum !== want.sum)
          report_mismatch($sformatf("result %0d: sum %0d, want %0d",
                                    results_seen, out_if.sum, want.sum));
        if (out_if.status !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                    results_seen, out_if.status, want.status));
      end
    end
  end

  // stimulus
  initial begin
    sat_cmd_t c;
    int phase;
    int pick;
    int roll;
    int rows;
    int cols;
    int side_cap;
    int random_start;
    bit stray_restart;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.func       = FN_RESTART;
    in_if.cell_value = '0;
    in_if.top_row    = '0;
    in_if.left_col   = '0;
    in_if.side       = '0;
    error_count      = 0;
    items_sent       = 0;
    results_seen     = 0;
    no_gaps          = 1'b0;
    rows_reg         = DIM_RESET;
    cols_reg         = DIM_RESET;
    restart_grid();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write)
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      else
        send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part: grid setup, full load with some noise, then queries
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < TARGET_ITEMS) begin
      // the one-row grid load runs with no idling at all
      no_gaps = (phase == 1);
      case (phase)
        0: begin
          write_register(CFG_COL_COUNT, 8'd1);
          write_register(CFG_ROW_COUNT, 8'd128);
        end
        1: begin
          write_register(CFG_ROW_COUNT, 8'd0);
          write_register(CFG_COL_COUNT, 8'd255);
        end
        2: begin
          write_register(CFG_ROW_COUNT, 8'd255);
          write_register(CFG_COL_COUNT, 8'd0);
        end
        default: begin
          pick = (phase == 3) ? 3 : $urandom_range(0, 3);
          if (pick == 0) send_item(random_cmd(FN_RESTART), 1'b0, '0);
          if ((pick & 1) != 0)
            write_register(CFG_ROW_COUNT, DIM_W'($urandom_range(1, SMALL_DIM)));
          if ((pick & 2) != 0)
            write_register(CFG_COL_COUNT, DIM_W'($urandom_range(1, SMALL_DIM)));
        end
      endcase
      rows = dim_in_use(rows_reg);
      cols = dim_in_use(cols_reg);

      // raster load, now and then broken by a stray command; at most one
      // stray restart per grid so that the load always finishes
      stray_restart = 1'b0;
      while (!grid_loaded) begin
        roll = $urandom_range(0, 99);
        if (roll < 2 && !stray_restart) begin
          c = random_cmd(FN_RESTART);
          stray_restart = 1'b1;
        end else if (roll < 5) begin
          c = random_cmd(FN_QUERY);
        end else if (roll < 7) begin
          c = random_cmd(FN_UNUSED);
        end else begin
          c = random_cmd(FN_LOAD);
          c.cell_value = random_cell();
        end
        send_item(c, 1'b0, '0);
      end

      // queries over the finished table
      side_cap = (rows < cols) ? rows : cols;
      repeat ($urandom_range(4, 14)) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          c = random_cmd(FN_QUERY);
          c.side     = SIDE_W'($urandom_range(1, side_cap));
          c.top_row  = CORNER_W'($urandom_range(0, rows - int'(c.side)));
          c.left_col = CORNER_W'($urandom_range(0, cols - int'(c.side)));
        end else if (roll < 75) begin
          c = random_cmd(FN_QUERY);
          c.side = '0;
        end else if (roll < 87) begin
          c = random_cmd(FN_QUERY);
        end else if (roll < 94) begin
          c = random_cmd(FN_LOAD);
        end else begin
          c = random_cmd(FN_UNUSED);
        end
        send_item(c, 1'b0, '0);
      end
      phase++;
    end

    // drain
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
